### hdl/pinhole_point_projection_core_defines.svh
// assertion macros for the pinhole projection core
// no dependencies; included by the files that carry checks
`ifndef PINHOLE_POINT_PROJECTION_CORE_DEFINES_SVH
`define PINHOLE_POINT_PROJECTION_CORE_DEFINES_SVH
`ifndef SYNTH
`define PPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("projection core check failed");
`define PPC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("projection core reset check failed");
`else
`define PPC_ASSERT(lbl, clk, rst_n, prop)
`define PPC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### hdl/ppc_pkg.sv
// shared widths, types and helpers for the pinhole projection core
// no dependencies
package ppc_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int CAM_FRAC_BITS   = 10;
    localparam int WORK_FRAC = (COORD_FRAC_BITS > CAM_FRAC_BITS) ? COORD_FRAC_BITS
                                                                 : CAM_FRAC_BITS;
    localparam int PT_SHIFT  = WORK_FRAC - COORD_FRAC_BITS;
    localparam int EYE_SHIFT = WORK_FRAC - CAM_FRAC_BITS;
    localparam int INV_SHIFT = WORK_FRAC - CAM_FRAC_BITS + COORD_FRAC_BITS;

    localparam int NCOMP     = 3;
    localparam int COMP_W    = 21;
    localparam int REG_W     = 63;
    localparam int PT_W      = 32;
    localparam int CFG_IDX_W = 8;

    // point minus eye
    localparam int D_W = (((PT_W + PT_SHIFT) > (COMP_W + EYE_SHIFT)) ? (PT_W + PT_SHIFT)
                                                                     : (COMP_W + EYE_SHIFT)) + 1;
    // cross products, split into an unsigned low and a signed high half
    localparam int CR_W     = 2 * COMP_W + 1;
    localparam int CR_LO_W  = CR_W - COMP_W;
    localparam int CR_HI_W  = CR_W - CR_LO_W;
    localparam int MUL_LO_W = CR_LO_W + 1 + D_W;
    localparam int MUL_HI_W = CR_HI_W + D_W;
    localparam int PROD_W   = CR_W + D_W;
    localparam int SUM_W    = PROD_W + 2;
    // determinant
    localparam int DLO_W   = CR_LO_W + 1 + COMP_W;
    localparam int DHI_W   = CR_HI_W + COMP_W;
    localparam int DPROD_W = CR_W + COMP_W;
    localparam int DET_W   = DPROD_W + 2;
    // divider
    localparam int NUM_W = ((SUM_W + COORD_FRAC_BITS) > (DET_W + INV_SHIFT))
                           ? (SUM_W + COORD_FRAC_BITS) : (DET_W + INV_SHIFT);
    localparam int DEN_W = SUM_W;
    localparam int Q_W   = 32;
    localparam int OUT_W = 32;
    localparam int INV_W = 31;

    localparam int FRONT_STAGES = 6;
    localparam int DIV_STAGES   = Q_W + 2;
    localparam int N_STAGES     = FRONT_STAGES + DIV_STAGES;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [INV_W-1:0] INV_MAX = {INV_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] IDX_AXIS_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] IDX_AXIS_B = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] IDX_CORNER = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] IDX_EYE    = CFG_IDX_W'(3);

    // camera set derived from the registers; cr index 0 b x c, 1 c x a, 2 a x b
    typedef struct packed {
        logic [NCOMP-1:0][NCOMP-1:0][CR_W-1:0] cr;
        logic [NCOMP-1:0][COMP_W-1:0]          eye;
        logic [DET_W-1:0]                      det;
    } t_cam;

    // divider entry word; lane 0 u, 1 v, 2 inverse depth
    typedef struct packed {
        logic [NCOMP-1:0][NUM_W-1:0] num;
        logic [DEN_W-1:0]            den;
        logic [NCOMP-1:0]            neg;
        logic                        bad;
    } t_div_word;

    typedef struct packed {
        logic             in_front;
        logic [OUT_W-1:0] u;
        logic [OUT_W-1:0] v;
        logic [INV_W-1:0] inv;
    } t_result;

    function automatic logic [COMP_W-1:0] f_comp(input logic [REG_W-1:0] rv, input int idx);
        return rv[COMP_W*idx +: COMP_W];
    endfunction

endpackage

### hdl/ppc_cfg.sv
// camera registers and the derived cross products and determinant
// depends on ppc_pkg
module ppc_cfg import ppc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    output t_cam                 o_cam
);

    logic [REG_W-1:0] r_axis_a;
    logic [REG_W-1:0] r_axis_b;
    logic [REG_W-1:0] r_corner;
    logic [REG_W-1:0] r_eye;

    logic signed [COMP_W-1:0]   w_vec [NCOMP][NCOMP];
    logic signed [2*COMP_W-1:0] r_m   [NCOMP][NCOMP][2];
    logic signed [CR_W-1:0]     r_cr  [NCOMP][NCOMP];
    logic signed [DLO_W-1:0]    r_dlo [NCOMP];
    logic signed [DHI_W-1:0]    r_dhi [NCOMP];
    logic signed [DPROD_W-1:0]  r_dp  [NCOMP];
    logic signed [DET_W-1:0]    r_det;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_a <= REG_W'(64'd1024);
            r_axis_b <= REG_W'(64'd4395899027456);
            r_corner <= '0;
            r_eye    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                IDX_AXIS_A: r_axis_a <= i_cfg_data;
                IDX_AXIS_B: r_axis_b <= i_cfg_data;
                IDX_CORNER: r_corner <= i_cfg_data;
                IDX_EYE:    r_eye    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // unpack a, b, c
    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            w_vec[0][i] = f_comp(r_axis_a, i);
            w_vec[1][i] = f_comp(r_axis_b, i);
            w_vec[2][i] = f_comp(r_corner, i);
        end
    end

    // free-running chain: cross products, then a . (b x c)
    always_ff @(posedge i_clk) begin
        for (int n = 0; n < NCOMP; n++) begin
            for (int i = 0; i < NCOMP; i++) begin
                r_m[n][i][0] <= w_vec[(n+1)%3][(i+1)%3] * w_vec[(n+2)%3][(i+2)%3];
                r_m[n][i][1] <= w_vec[(n+1)%3][(i+2)%3] * w_vec[(n+2)%3][(i+1)%3];
                r_cr[n][i]   <= CR_W'(r_m[n][i][0]) - CR_W'(r_m[n][i][1]);
            end
        end
        for (int i = 0; i < NCOMP; i++) begin
            r_dlo[i] <= $signed({1'b0, r_cr[0][i][CR_LO_W-1:0]}) * w_vec[0][i];
            r_dhi[i] <= $signed(r_cr[0][i][CR_W-1:CR_LO_W]) * w_vec[0][i];
            r_dp[i]  <= (DPROD_W'(r_dhi[i]) <<< CR_LO_W) + DPROD_W'(r_dlo[i]);
        end
        r_det <= DET_W'(r_dp[0]) + DET_W'(r_dp[1]) + DET_W'(r_dp[2]);
    end

    // camera word
    always_comb begin
        for (int n = 0; n < NCOMP; n++) begin
            for (int i = 0; i < NCOMP; i++) begin
                o_cam.cr[n][i] = r_cr[n][i];
            end
        end
        for (int i = 0; i < NCOMP; i++) begin
            o_cam.eye[i] = f_comp(r_eye, i);
        end
        o_cam.det = r_det;
    end

endmodule

### hdl/ppc_dot.sv
// front pipeline: point minus eye, dot products with the cross products,
// magnitudes and signs for the divider; depends on ppc_pkg
module ppc_dot import ppc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  t_cam                   i_cam,
    input  logic signed [PT_W-1:0] i_point_x,
    input  logic signed [PT_W-1:0] i_point_y,
    input  logic signed [PT_W-1:0] i_point_z,
    output t_div_word              o_word
);

    logic signed [PT_W-1:0]     r_p  [NCOMP];
    logic signed [D_W-1:0]      r_d  [NCOMP];
    logic signed [MUL_LO_W-1:0] r_lo [NCOMP][NCOMP];
    logic signed [MUL_HI_W-1:0] r_hi [NCOMP][NCOMP];
    logic signed [PROD_W-1:0]   r_pp [NCOMP][NCOMP];
    logic signed [SUM_W-1:0]    r_n  [NCOMP];
    t_div_word                  r_word;
    t_div_word                  n_word;

    logic signed [DET_W-1:0] w_det;
    logic                    w_det_neg;
    logic                    w_nz_neg;
    logic [SUM_W-1:0]        w_mag [NCOMP];
    logic [DET_W-1:0]        w_det_mag;

    // stages 0 to 5
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_point_x;
            r_p[1] <= i_point_y;
            r_p[2] <= i_point_z;
            for (int i = 0; i < NCOMP; i++) begin
                r_d[i] <= (D_W'(r_p[i]) <<< PT_SHIFT)
                        - (D_W'($signed(i_cam.eye[i])) <<< EYE_SHIFT);
            end
            for (int n = 0; n < NCOMP; n++) begin
                for (int i = 0; i < NCOMP; i++) begin
                    r_lo[n][i] <= $signed({1'b0, i_cam.cr[n][i][CR_LO_W-1:0]}) * r_d[i];
                    r_hi[n][i] <= $signed(i_cam.cr[n][i][CR_W-1:CR_LO_W]) * r_d[i];
                    r_pp[n][i] <= (PROD_W'(r_hi[n][i]) <<< CR_LO_W) + PROD_W'(r_lo[n][i]);
                end
                r_n[n] <= SUM_W'(r_pp[n][0]) + SUM_W'(r_pp[n][1]) + SUM_W'(r_pp[n][2]);
            end
            r_word <= n_word;
        end
    end

    // magnitudes, quotient signs and the invalid test
    always_comb begin
        w_det     = $signed(i_cam.det);
        w_det_neg = w_det[DET_W-1];
        w_nz_neg  = r_n[2][SUM_W-1];
        w_det_mag = w_det_neg ? DET_W'(-w_det) : DET_W'(w_det);
        for (int n = 0; n < NCOMP; n++) begin
            w_mag[n] = r_n[n][SUM_W-1] ? SUM_W'(-r_n[n]) : SUM_W'(r_n[n]);
        end
        n_word.num[0] = NUM_W'(w_mag[0]) << COORD_FRAC_BITS;
        n_word.num[1] = NUM_W'(w_mag[1]) << COORD_FRAC_BITS;
        n_word.num[2] = NUM_W'(w_det_mag) << INV_SHIFT;
        n_word.den    = w_mag[2];
        n_word.neg[0] = r_n[0][SUM_W-1] ^ w_nz_neg;
        n_word.neg[1] = r_n[1][SUM_W-1] ^ w_nz_neg;
        n_word.neg[2] = w_det_neg ^ w_nz_neg;
        n_word.bad    = (w_det == '0) || (r_n[2] == '0) || (w_det_neg != w_nz_neg);
    end

    assign o_word = r_word;

endmodule

### hdl/ppc_div.sv
// three-lane restoring divider, one quotient bit per stage, then rounding
// and saturation; depends on ppc_pkg and the assertion macro header
`include "pinhole_point_projection_core_defines.svh"
module ppc_div import ppc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [DIV_STAGES-1:0] i_valid,
    input  t_div_word             i_word,
    output t_result               o_res
);

    logic [NUM_W-1:0] r_rem [Q_W+1][NCOMP];
    logic [Q_W-1:0]   r_q   [Q_W+1][NCOMP];
    logic [DEN_W-1:0] r_den [Q_W+1];
    logic [NCOMP-1:0] r_neg [Q_W+1];
    logic [NCOMP-1:0] r_sat [Q_W+1];
    logic             r_bad [Q_W+1];
    t_result          r_res;
    t_result          n_res;

    logic             w_up [NCOMP];
    logic [Q_W:0]     w_m  [NCOMP];

    function automatic logic [OUT_W-1:0] f_clamp_s(input logic [Q_W:0] m, input logic neg,
                                                   input logic sat);
        if (!neg) begin
            return (sat || (m > (Q_W+1)'(OUT_MAX))) ? OUT_MAX : OUT_W'(m);
        end
        return (sat || (m > (Q_W+1)'(OUT_MIN))) ? OUT_MIN : OUT_W'(-m);
    endfunction

    function automatic logic [INV_W-1:0] f_clamp_u(input logic [Q_W:0] m, input logic neg,
                                                   input logic sat);
        if (neg) begin
            return '0;
        end
        return (sat || (m > (Q_W+1)'(INV_MAX))) ? INV_MAX : INV_W'(m);
    endfunction

    // overflow check stage and the quotient bit stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_word.den;
            r_neg[0] <= i_word.neg;
            r_bad[0] <= i_word.bad;
            for (int l = 0; l < NCOMP; l++) begin
                r_rem[0][l] <= i_word.num[l];
                r_q[0][l]   <= '0;
                r_sat[0][l] <= (i_word.num[l] >> Q_W) >= NUM_W'(i_word.den);
            end
            for (int j = 1; j <= Q_W; j++) begin
                r_den[j] <= r_den[j-1];
                r_neg[j] <= r_neg[j-1];
                r_sat[j] <= r_sat[j-1];
                r_bad[j] <= r_bad[j-1];
                for (int l = 0; l < NCOMP; l++) begin
                    if ((r_rem[j-1][l] >> (Q_W - j)) >= NUM_W'(r_den[j-1])) begin
                        r_rem[j][l] <= r_rem[j-1][l] - (NUM_W'(r_den[j-1]) << (Q_W - j));
                        r_q[j][l]   <= r_q[j-1][l] | (Q_W'(1) << (Q_W - j));
                    end else begin
                        r_rem[j][l] <= r_rem[j-1][l];
                        r_q[j][l]   <= r_q[j-1][l];
                    end
                end
            end
            r_res <= n_res;
        end
    end

    // round half up, sign, saturate, invalid override
    always_comb begin
        for (int l = 0; l < NCOMP; l++) begin
            w_up[l] = {r_rem[Q_W][l][DEN_W-1:0], 1'b0} >= {1'b0, r_den[Q_W]};
            w_m[l]  = {1'b0, r_q[Q_W][l]} + (Q_W+1)'(w_up[l]);
        end
        if (r_bad[Q_W]) begin
            n_res.in_front = 1'b0;
            n_res.u        = OUT_MAX;
            n_res.v        = '0;
            n_res.inv      = '0;
        end else begin
            n_res.in_front = 1'b1;
            n_res.u        = f_clamp_s(w_m[0], r_neg[Q_W][0], r_sat[Q_W][0]);
            n_res.v        = f_clamp_s(w_m[1], r_neg[Q_W][1], r_sat[Q_W][1]);
            n_res.inv      = f_clamp_u(w_m[2], r_neg[Q_W][2], r_sat[Q_W][2]);
        end
    end

    assign o_res = r_res;

    // restoring division must end with a remainder below the divisor
    `PPC_ASSERT(a_rem_below_den, i_clk, i_rst_n, (i_valid[Q_W] && !r_bad[Q_W] && !r_sat[Q_W][0]) |-> (r_rem[Q_W][0] < NUM_W'(r_den[Q_W])))

endmodule

### hdl/pinhole_point_projection_core.sv
// Pinhole point projection core. Each accepted point word yields one result
// word; a new point can be accepted every clock while the skid buffer is empty.
// The path is six front stages (input register, subtract, multiply, combine,
// sum, magnitude), the 34-stage divider (overflow check, one quotient bit per
// stage for 32 bits, rounding) and the output register. A one-word skid buffer
// behind the pipeline lets the input keep flowing while a result waits.
// After a camera register write the derived cross products and determinant
// are recomputed in their own registered chain; points accepted from the cycle
// after the write see the new camera.
// depends on ppc_pkg, ppc_cfg, ppc_dot, ppc_div and the assertion macro header
`include "pinhole_point_projection_core_defines.svh"
module pinhole_point_projection_core import ppc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [REG_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [PT_W-1:0] i_point_x,
    input  logic signed [PT_W-1:0] i_point_y,
    input  logic signed [PT_W-1:0] i_point_z,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_in_front,
    output logic signed [OUT_W-1:0] o_image_u,
    output logic signed [OUT_W-1:0] o_image_v,
    output logic [INV_W-1:0]       o_inverse_depth
);

    t_cam                w_cam;
    t_div_word           w_word;
    t_result             w_res;
    logic [N_STAGES-1:0] r_valid;
    logic                w_en;
    logic                w_fin;
    logic                w_take;
    t_result             r_out;
    t_result             r_skid;
    logic                r_out_v;
    logic                r_skid_v;

    ppc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cam      (w_cam)
    );

    ppc_dot u_dot (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_cam     (w_cam),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .o_word    (w_word)
    );

    ppc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_valid[N_STAGES-1:FRONT_STAGES]),
        .i_word  (w_word),
        .o_res   (w_res)
    );

    // pipeline advances whenever the skid stage is free
    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;
    assign w_fin      = w_en && r_valid[N_STAGES-1];
    assign w_take     = r_out_v && i_out_ready;

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[N_STAGES-2:0], i_in_valid};
        end
    end

    // output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || w_take) begin
            r_out_v <= w_fin;
        end else if (w_fin) begin
            r_skid_v <= 1'b1;
        end
    end

    // output register and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || w_take) begin
            if (w_fin) begin
                r_out <= w_res;
            end
        end else if (w_fin) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_in_front      = r_out.in_front;
    assign o_image_u       = r_out.u;
    assign o_image_v       = r_out.v;
    assign o_inverse_depth = r_out.inv;

    // reset empties the whole pipeline
    `PPC_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> (r_valid == '0 && !r_out_v && !r_skid_v))
    // the skid stage only fills behind a held output word
    `PPC_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_v |-> r_out_v)
    // an invalid projection carries the fixed filler values
    `PPC_ASSERT(a_invalid_word, i_clk, i_rst_n, (o_out_valid && !o_in_front) |-> (o_image_u == OUT_MAX && o_image_v == '0 && o_inverse_depth == '0))

endmodule
